>>> rtl/wheel_velocity_pi_controller_top_assert.svh
// Assertion macros shared by the wheel velocity PI controller modules.
// Expects clk and arst_n in the including scope; no other dependencies.
`ifndef WHEEL_VELOCITY_PI_CONTROLLER_TOP_ASSERT_SVH
`define WHEEL_VELOCITY_PI_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define WVPI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define WVPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/wvpi_pkg.sv
// Package for the wheel velocity PI controller: types, codes, reset values,
// Q16.16 rounding and saturation helpers. No dependencies.
`timescale 1ns / 1ps

package wvpi_pkg;

	// Request codes on req_type
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_SET   = 2'd1,
		REQ_SPEED = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Result kinds
	typedef enum logic {
		KIND_DRIVE = 1'b0,
		KIND_SPEED = 1'b1
	} kind_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_PROP_GAIN       = 3'd0,
		CFG_SETPOINT_WEIGHT = 3'd1,
		CFG_INV_PERIOD      = 3'd2,
		CFG_VEL_FILTER_COEF = 3'd3,
		CFG_REF_FILTER_COEF = 3'd4,
		CFG_INT_GAIN        = 3'd5,
		CFG_TRACK_GAIN      = 3'd6,
		CFG_OUT_LIMIT       = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [30:0] prop_gain;
		logic [17:0] setpoint_weight;
		logic [30:0] inv_period;
		logic [16:0] vel_filter_coef;
		logic [16:0] ref_filter_coef;
		logic [30:0] int_gain;
		logic [30:0] track_gain;
		logic [30:0] out_limit;
	} cfg_t;

	localparam logic [30:0] RST_PROP_GAIN       = 31'd170394;
	localparam logic [17:0] RST_SETPOINT_WEIGHT = 18'd58982;
	localparam logic [30:0] RST_INV_PERIOD      = 31'd655360;
	localparam logic [16:0] RST_VEL_FILTER_COEF = 17'd13107;
	localparam logic [16:0] RST_REF_FILTER_COEF = 17'd13107;
	localparam logic [30:0] RST_INT_GAIN        = 31'd17039;
	localparam logic [30:0] RST_TRACK_GAIN      = 31'd1311;
	localparam logic [30:0] RST_OUT_LIMIT       = 31'd196608;

	localparam logic signed [31:0] WHEEL_RADIUS_Q = 32'sd196608;
	localparam logic signed [17:0] ONE_Q          = 18'sd65536;

	localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
	localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAW_MUL,
		ST_RF1,
		ST_RF2,
		ST_Y1,
		ST_Y2,
		ST_Y_SUM,
		ST_PW,
		ST_KP,
		ST_V,
		ST_CLAMP,
		ST_TRACK,
		ST_COMMIT,
		ST_SPD_MUL,
		ST_SPD_OUT
	} state_t;

	// Multiplier operand pairs
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_D_INV,
		MUL_RS_1MA,
		MUL_RP_A,
		MUL_RAW_1MB,
		MUL_VP_B,
		MUL_BETA_RF,
		MUL_K_PW,
		MUL_IG_E,
		MUL_TG_CORR,
		MUL_VEL_R
	} mul_sel_t;

	// Operations on the registered product
	typedef enum logic [3:0] {
		POST_NONE,
		POST_RAW,
		POST_ACC,
		POST_RF,
		POST_Y,
		POST_PW,
		POST_V,
		POST_CLAMP,
		POST_COMMIT,
		POST_SPEED
	} post_t;

	// Controller to datapath commands
	typedef struct packed {
		mul_sel_t mul_sel;
		post_t    post;
		logic     load_tick;
		logic     set_ref;
	} cmd_t;

	// Round to nearest, halves toward +inf: floor((x + 2^15) / 2^16)
	function automatic logic signed [49:0] rnd_q(input logic signed [65:0] x);
		logic signed [65:0] t;
		t = x + 66'sd32768;
		return t[65:16];
	endfunction

	// Saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
		logic signed [31:0] r;
		if (x > SAT_HI) begin
			r = 32'sh7fffffff;
		end else if (x < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/wvpi_cfg_regs.sv
// Configuration register file: write decode, width masking, reset values.
// Depends on wvpi_pkg.
`timescale 1ns / 1ps

module wvpi_cfg_regs
	import wvpi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [30:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// Register writes; narrower fields keep the low bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= RST_PROP_GAIN;
			cfg_q.setpoint_weight <= RST_SETPOINT_WEIGHT;
			cfg_q.inv_period      <= RST_INV_PERIOD;
			cfg_q.vel_filter_coef <= RST_VEL_FILTER_COEF;
			cfg_q.ref_filter_coef <= RST_REF_FILTER_COEF;
			cfg_q.int_gain        <= RST_INT_GAIN;
			cfg_q.track_gain      <= RST_TRACK_GAIN;
			cfg_q.out_limit       <= RST_OUT_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_PROP_GAIN:       cfg_q.prop_gain       <= cfg_wdata;
				CFG_SETPOINT_WEIGHT: cfg_q.setpoint_weight <= cfg_wdata[17:0];
				CFG_INV_PERIOD:      cfg_q.inv_period      <= cfg_wdata;
				CFG_VEL_FILTER_COEF: cfg_q.vel_filter_coef <= cfg_wdata[16:0];
				CFG_REF_FILTER_COEF: cfg_q.ref_filter_coef <= cfg_wdata[16:0];
				CFG_INT_GAIN:        cfg_q.int_gain        <= cfg_wdata;
				CFG_TRACK_GAIN:      cfg_q.track_gain      <= cfg_wdata;
				CFG_OUT_LIMIT:       cfg_q.out_limit       <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/wvpi_datapath.sv
// Datapath: regulator state, one shared 33x32 multiplier with registered
// product, post-processing of the product and the result register.
// Depends on wvpi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "wheel_velocity_pi_controller_top_assert.svh"

module wvpi_datapath
	import wvpi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  cfg_t               cfg,
	input  logic signed [31:0] angle_sample,
	input  logic signed [31:0] ref_velocity,
	output logic               result_kind,
	output logic signed [31:0] drive,
	output logic signed [31:0] filtered_ref,
	output logic signed [31:0] filtered_vel,
	output logic signed [31:0] linear_speed
);

	// Regulator state
	logic signed [31:0] angle_prev_q, vel_q, ref_target_q, ref_prev_q;
	logic signed [31:0] ref_smooth_q, integ_q;

	// Intermediates of one tick
	logic signed [31:0] angle_q, raw_q, rf_q, y_q, pw_q, u_q, corr_q;
	logic signed [32:0] diff_q, e_q;
	logic signed [65:0] acc_q;
	logic signed [49:0] v_q, ie_q;
	logic signed [64:0] prod_s1;

	// Result register
	kind_t              kind_q;
	logic signed [31:0] drive_q, fref_q, fvel_q, speed_q;

	logic signed [17:0] coef_1ma, coef_1mb;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [64:0] mul_p;
	logic signed [65:0] prod66, sum66;
	logic signed [49:0] rnd_p, rnd_sum, lim, nlim, u_full;

	// Filter complements, may go negative for coefficients above one
	assign coef_1ma = ONE_Q - $signed({1'b0, cfg.ref_filter_coef});
	assign coef_1mb = ONE_Q - $signed({1'b0, cfg.vel_filter_coef});

	// Multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_D_INV: begin
				mul_a = diff_q;
				mul_b = $signed({1'b0, cfg.inv_period});
			end
			MUL_RS_1MA: begin
				mul_a = 33'(ref_smooth_q);
				mul_b = 32'(coef_1ma);
			end
			MUL_RP_A: begin
				mul_a = 33'(ref_prev_q);
				mul_b = $signed({15'd0, cfg.ref_filter_coef});
			end
			MUL_RAW_1MB: begin
				mul_a = 33'(raw_q);
				mul_b = 32'(coef_1mb);
			end
			MUL_VP_B: begin
				mul_a = 33'(vel_q);
				mul_b = $signed({15'd0, cfg.vel_filter_coef});
			end
			MUL_BETA_RF: begin
				mul_a = 33'(rf_q);
				mul_b = $signed({14'd0, cfg.setpoint_weight});
			end
			MUL_K_PW: begin
				mul_a = 33'(pw_q);
				mul_b = $signed({1'b0, cfg.prop_gain});
			end
			MUL_IG_E: begin
				mul_a = e_q;
				mul_b = $signed({1'b0, cfg.int_gain});
			end
			MUL_TG_CORR: begin
				mul_a = 33'(corr_q);
				mul_b = $signed({1'b0, cfg.track_gain});
			end
			MUL_VEL_R: begin
				mul_a = 33'(vel_q);
				mul_b = WHEEL_RADIUS_Q;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = 65'(mul_a) * 65'(mul_b);

	// Product register
	always_ff @(posedge clk) begin
		if (cmd.mul_sel != MUL_NONE) begin
			prod_s1 <= mul_p;
		end
	end

	// Rounding of the product, alone or added to the partial sum
	assign prod66  = 66'(prod_s1);
	assign sum66   = acc_q + prod66;
	assign rnd_p   = rnd_q(prod66);
	assign rnd_sum = rnd_q(sum66);

	// Output clamp
	assign lim  = $signed({19'd0, cfg.out_limit});
	assign nlim = -lim;
	always_comb begin
		if (v_q > lim) begin
			u_full = lim;
		end else if (v_q < nlim) begin
			u_full = nlim;
		end else begin
			u_full = v_q;
		end
	end

	// Tick intermediates
	always_ff @(posedge clk) begin
		if (cmd.load_tick) begin
			angle_q <= angle_sample;
			diff_q  <= 33'(angle_sample) - 33'(angle_prev_q);
		end
		unique case (cmd.post)
			POST_RAW: raw_q <= sat32(rnd_p);
			POST_ACC: acc_q <= prod66;
			POST_RF:  rf_q  <= sat32(rnd_sum);
			POST_Y:   y_q   <= sat32(rnd_sum);
			POST_PW: begin
				pw_q <= sat32(rnd_p - 50'(y_q));
				e_q  <= 33'(rf_q) - 33'(y_q);
			end
			POST_V: v_q <= rnd_p + 50'(integ_q);
			POST_CLAMP: begin
				ie_q   <= rnd_p;
				u_q    <= u_full[31:0];
				corr_q <= sat32(u_full - v_q);
			end
			default: begin
			end
		endcase
	end

	// Regulator state update and reference store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_prev_q <= '0;
			vel_q        <= '0;
			ref_target_q <= '0;
			ref_prev_q   <= '0;
			ref_smooth_q <= '0;
			integ_q      <= '0;
		end else begin
			if (cmd.set_ref) begin
				ref_target_q <= ref_velocity;
			end
			if (cmd.post == POST_COMMIT) begin
				angle_prev_q <= angle_q;
				vel_q        <= y_q;
				ref_prev_q   <= ref_target_q;
				ref_smooth_q <= rf_q;
				integ_q      <= sat32(50'(integ_q) + ie_q + rnd_p);
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.post == POST_COMMIT) begin
			kind_q  <= KIND_DRIVE;
			drive_q <= u_q;
			fref_q  <= rf_q;
			fvel_q  <= y_q;
			speed_q <= '0;
		end else if (cmd.post == POST_SPEED) begin
			kind_q  <= KIND_SPEED;
			drive_q <= '0;
			fref_q  <= '0;
			fvel_q  <= '0;
			speed_q <= sat32(rnd_p);
		end
	end

	assign result_kind  = kind_q;
	assign drive        = drive_q;
	assign filtered_ref = fref_q;
	assign filtered_vel = fvel_q;
	assign linear_speed = speed_q;

	`WVPI_ASSERT_NEXT(a_drive_in_limit, cmd.post == POST_CLAMP,
		(50'(u_q) <= lim) && (50'(u_q) >= nlim), "drive outside clamp")
	`WVPI_ASSERT_NEXT(a_set_ref_stored, cmd.set_ref,
		ref_target_q == $past(ref_velocity), "reference not stored")
	`WVPI_ASSERT_NEXT(a_commit_matches_result, cmd.post == POST_COMMIT,
		(ref_smooth_q == filtered_ref) && (vel_q == filtered_vel), "state and result differ")

endmodule

>>> rtl/wvpi_ctrl.sv
// Controller: sequences one item through the shared multiplier and owns
// the input ready and result valid flags. Depends on wvpi_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "wheel_velocity_pi_controller_top_assert.svh"

module wvpi_ctrl
	import wvpi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic       out_ready,
	output logic       out_valid,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept, out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_type == REQ_TICK) begin
					state_d = ST_RAW_MUL;
				end else if (accept && req_type == REQ_SPEED) begin
					state_d = ST_SPD_MUL;
				end
			end
			ST_RAW_MUL: state_d = ST_RF1;
			ST_RF1:     state_d = ST_RF2;
			ST_RF2:     state_d = ST_Y1;
			ST_Y1:      state_d = ST_Y2;
			ST_Y2:      state_d = ST_Y_SUM;
			ST_Y_SUM:   state_d = ST_PW;
			ST_PW:      state_d = ST_KP;
			ST_KP:      state_d = ST_V;
			ST_V:       state_d = ST_CLAMP;
			ST_CLAMP:   state_d = ST_TRACK;
			ST_TRACK:   state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SPD_MUL: state_d = ST_SPD_OUT;
			ST_SPD_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands; product post ops overlap the next multiply
	always_comb begin
		cmd = '{mul_sel: MUL_NONE, post: POST_NONE, load_tick: 1'b0, set_ref: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_tick = accept && (req_type == REQ_TICK);
				cmd.set_ref   = accept && (req_type == REQ_SET);
			end
			ST_RAW_MUL: cmd.mul_sel = MUL_D_INV;
			ST_RF1: begin
				cmd.post    = POST_RAW;
				cmd.mul_sel = MUL_RS_1MA;
			end
			ST_RF2: begin
				cmd.post    = POST_ACC;
				cmd.mul_sel = MUL_RP_A;
			end
			ST_Y1: begin
				cmd.post    = POST_RF;
				cmd.mul_sel = MUL_RAW_1MB;
			end
			ST_Y2: begin
				cmd.post    = POST_ACC;
				cmd.mul_sel = MUL_VP_B;
			end
			ST_Y_SUM: begin
				cmd.post    = POST_Y;
				cmd.mul_sel = MUL_BETA_RF;
			end
			ST_PW:  cmd.post = POST_PW;
			ST_KP:  cmd.mul_sel = MUL_K_PW;
			ST_V: begin
				cmd.post    = POST_V;
				cmd.mul_sel = MUL_IG_E;
			end
			ST_CLAMP: cmd.post = POST_CLAMP;
			ST_TRACK: cmd.mul_sel = MUL_TG_CORR;
			ST_COMMIT: begin
				if (out_free) begin
					cmd.post = POST_COMMIT;
				end
			end
			ST_SPD_MUL: cmd.mul_sel = MUL_VEL_R;
			ST_SPD_OUT: begin
				if (out_free) begin
					cmd.post = POST_SPEED;
				end
			end
			default: begin
			end
		endcase
	end

	// State and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.post == POST_COMMIT || cmd.post == POST_SPEED) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`WVPI_ASSERT_NEXT(a_tick_starts, accept && req_type == REQ_TICK,
		state_q == ST_RAW_MUL, "tick did not start sequence")
	`WVPI_ASSERT_NEXT(a_set_stays_idle, accept && req_type == REQ_SET,
		state_q == ST_IDLE, "set item left idle")
	`WVPI_ASSERT_NOW(a_result_from_final, $rose(out_valid_q),
		$past(state_q) == ST_COMMIT || $past(state_q) == ST_SPD_OUT,
		"result raised outside a final step")

endmodule

>>> rtl/wheel_velocity_pi_controller_top.sv
// Channel   Handshake            Payload
// in        in_valid/in_ready    req_type, angle_sample, ref_velocity
// out       out_valid/out_ready  result_kind, drive, filtered_ref, filtered_vel,
//                                linear_speed
// cfg       cfg_we               cfg_idx, cfg_wdata
//
// A tick: the result is registered in the commit step after RAW_MUL through TRACK;
// nine products pass in turn through the one shared 33x32 multiplier, then idle.
// Velocity request: SPD_MUL then SPD_OUT; a set item stays in idle; code 3 dropped.
// Asynchronous reset clears state, config to defaults and the result flag.
// The result register lets a new item in while a result waits; a tick or
// request whose result is ready holds in its final step until that transfer.
//
// Top level of the wheel velocity PI controller; instantiates wvpi_cfg_regs,
// wvpi_ctrl and wvpi_datapath. Depends on wvpi_pkg.
`timescale 1ns / 1ps

module wheel_velocity_pi_controller_top
	import wvpi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [30:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] angle_sample,
	input  logic signed [31:0] ref_velocity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               result_kind,
	output logic signed [31:0] drive,
	output logic signed [31:0] filtered_ref,
	output logic signed [31:0] filtered_vel,
	output logic signed [31:0] linear_speed
);

	cfg_t cfg;
	cmd_t cmd;

	wvpi_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	wvpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	wvpi_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.angle_sample (angle_sample),
		.ref_velocity (ref_velocity),
		.result_kind  (result_kind),
		.drive        (drive),
		.filtered_ref (filtered_ref),
		.filtered_vel (filtered_vel),
		.linear_speed (linear_speed)
	);

endmodule
